// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the polyline height lookup.
// No dependencies; the synthesis branch defines every macro with an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Overlapping implication checked on every clock edge out of reset
`define PHLU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked on every clock edge out of reset
`define PHLU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PHLU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PHLU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/phlu_pkg.sv -----
// Package for the polyline height lookup: state types, opcodes, field widths.
// No dependencies.
package phlu_pkg;

    // Opcodes of an input transaction
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Fixed field widths
    localparam int COUNT_BITS = 7;
    localparam int INDEX_BITS = 6;

    // Top-level control sequencer
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EVAL = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } ctl_state_t;

    // Divider sequencer
    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_MUL  = 3'b010,
        D_RUN  = 3'b100
    } div_state_t;

    // Divider status toward the control sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/phlu_vertex_mem.sv -----
// Vertex table: single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module phlu_vertex_mem #(
    parameter int DEPTH     = 64,
    parameter int WIDTH     = 48,
    parameter int ADDR_BITS = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/phlu_divider.sv -----
// Multiply-then-divide unit: q = (a * b) / d, unsigned, truncated.
// A multiply step, then a restoring divider, one quotient bit per cycle. Uses phlu_pkg.
module phlu_divider #(
    parameter int COORD_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [COORD_BITS-1:0]     a,
    input  logic [COORD_BITS:0]       b,
    input  logic [COORD_BITS-1:0]     d,
    output logic [2*COORD_BITS:0]     quotient,
    output phlu_pkg::div_stat_t       stat
);

    import phlu_pkg::*;

    localparam int PROD_BITS = 2 * COORD_BITS + 1;
    localparam int CNT_BITS  = $clog2(PROD_BITS + 1);

    div_state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     done_reg;
    logic [COORD_BITS-1:0]    a_reg;
    logic [COORD_BITS:0]      b_reg;
    logic [COORD_BITS-1:0]    d_reg;
    logic [PROD_BITS-1:0]     prod_full;
    logic [PROD_BITS-1:0]     prod_reg;
    logic [COORD_BITS-1:0]    rem_reg;
    logic [COORD_BITS:0]      rem_shift;
    logic [COORD_BITS:0]      rem_diff;
    logic                     q_bit;

    // Full-width product of the captured operands
    assign prod_full = a_reg * b_reg;

    // One restoring step: shift in the next dividend bit, try subtract
    always_comb
    begin
        rem_shift = {rem_reg, prod_reg[PROD_BITS-1]};
        rem_diff  = rem_shift - {1'b0, d_reg};
        q_bit     = (rem_shift >= {1'b0, d_reg});
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:  if (start) state_next = D_MUL;
            D_MUL:   state_next = D_RUN;
            D_RUN:   if (cnt_reg == CNT_BITS'(1)) state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_RUN) && (cnt_reg == CNT_BITS'(1));
            if (state_reg == D_MUL)
            begin
                cnt_reg <= CNT_BITS'(PROD_BITS);
            end
            else if (state_reg == D_RUN)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Datapath: operand capture, product, shift-subtract
    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    a_reg <= a;
                    b_reg <= b;
                    d_reg <= d;
                end
            end
            D_MUL:
            begin
                prod_reg <= prod_full;
                rem_reg  <= '0;
            end
            D_RUN:
            begin
                rem_reg  <= q_bit ? rem_diff[COORD_BITS-1:0] : rem_shift[COORD_BITS-1:0];
                prod_reg <= {prod_reg[PROD_BITS-2:0], q_bit};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign quotient  = prod_reg;
    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = done_reg;

endmodule

// ----- rtl/polyline_height_lookup_unit.sv -----
// Polyline height lookup: vertex table in RAM, segment scan, multiply-divide interpolation.
// A vertex write gives no result. A query scans n = min(point_count, MAX_POINTS) entries
// (no scan if n < 2), then evaluates and, when the segment needs the divide, runs the
// multiply-divide; the next query is accepted once the result enters the output register.
// One transaction in work at a time; the output register lets the next one enter while
// a result waits. Reset (rst_n, async, low) clears control and point_count, not the table.
`include "assert_macros.svh"

module polyline_height_lookup_unit #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write_en,
    input  logic [phlu_pkg::COUNT_BITS-1:0]      cfg_write_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [phlu_pkg::INDEX_BITS-1:0]      point_index,
    input  logic signed [COORD_BITS-1:0]         x_value,
    input  logic signed [COORD_BITS-1:0]         y_value,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 on_rail,
    output logic signed [COORD_BITS-1:0]         height,
    output logic                                 vertical_segment
);

    import phlu_pkg::*;

    localparam int C         = COORD_BITS;
    localparam int ADDR_BITS = $clog2(MAX_POINTS);
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int CNT_BITS  = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;
    localparam int PROD_BITS = 2 * C + 1;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam logic [SUM_BITS-1:0] SAT_HI = {{(SUM_BITS-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic [SUM_BITS-1:0] SAT_LO = {{(SUM_BITS-C+1){1'b1}}, {(C-1){1'b0}}};

    ctl_state_t               state_reg, state_next;
    logic [COUNT_BITS-1:0]    point_count_reg;
    logic [CNT_BITS-1:0]      idx_reg;
    logic [CNT_BITS-1:0]      n_eff;
    logic [CNT_BITS-1:0]      count_ext;
    logic                     accept, is_query, slot_ok;
    logic                     found_reg, vert_hit_reg;
    logic signed [C-1:0]      qx_reg;
    logic signed [C-1:0]      prev_x_reg, prev_y_reg;
    logic signed [C-1:0]      seg_y3_reg;
    logic [C-1:0]             seg_a_reg, seg_d_reg;
    logic [C:0]               seg_dy_reg;
    logic [ADDR_BITS-1:0]     rd_addr;
    logic [2*C-1:0]           rd_data;
    logic signed [C-1:0]      rd_x, rd_y;
    logic                     seg_hit;
    logic [C:0]               diff_a, diff_d, diff_dy;
    logic [C:0]               b_abs;
    logic                     div_start;
    logic [PROD_BITS-1:0]     quotient;
    div_stat_t                div_stat;
    logic [SUM_BITS-1:0]      y3_ext, q_ext, sum;
    logic signed [C-1:0]      sat_height;
    logic                     res_on_rail_reg, res_vert_reg;
    logic signed [C-1:0]      res_height_reg;
    logic                     out_load;
    logic                     out_valid_reg, on_rail_reg, vert_reg;
    logic signed [C-1:0]      height_reg;

    // Handshake and decode
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign is_query = accept && (opcode == OP_QUERY);
    assign slot_ok  = (32'(point_index) < 32'(MAX_POINTS));

    // Effective vertex count, clamped to table depth
    assign count_ext = CNT_BITS'(point_count_reg);
    assign n_eff     = (count_ext > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS) : count_ext;

    // Vertex RAM: address 0 on query accept, next entry while scanning
    assign rd_addr = (state_reg == S_SCAN) ? ADDR_BITS'(idx_reg + 1'b1) : '0;

    phlu_vertex_mem #(
        .DEPTH     (MAX_POINTS),
        .WIDTH     (2 * C),
        .ADDR_BITS (ADDR_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept && (opcode == OP_WRITE) && slot_ok),
        .wr_addr (ADDR_BITS'(point_index)),
        .wr_data ({x_value, y_value}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_x = rd_data[2*C-1:C];
    assign rd_y = rd_data[C-1:0];

    // Segment test between previous entry and the entry just read
    always_comb
    begin
        seg_hit = (state_reg == S_SCAN) && (idx_reg != '0) &&
                  (qx_reg >= prev_x_reg) && (qx_reg <= rd_x);
        diff_a  = {qx_reg[C-1], qx_reg} - {prev_x_reg[C-1], prev_x_reg};
        diff_d  = {rd_x[C-1], rd_x} - {prev_x_reg[C-1], prev_x_reg};
        diff_dy = {rd_y[C-1], rd_y} - {prev_y_reg[C-1], prev_y_reg};
    end

    // Divider operands
    assign b_abs     = seg_dy_reg[C] ? (~seg_dy_reg + 1'b1) : seg_dy_reg;
    assign div_start = (state_reg == S_EVAL) && found_reg && !vert_hit_reg;

    phlu_divider #(
        .COORD_BITS (C)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .a        (seg_a_reg),
        .b        (b_abs),
        .d        (seg_d_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Apply quotient to y3 and saturate
    always_comb
    begin
        y3_ext = {{(SUM_BITS-C){seg_y3_reg[C-1]}}, seg_y3_reg};
        q_ext  = {2'b00, quotient};
        sum    = seg_dy_reg[C] ? (y3_ext - q_ext) : (y3_ext + q_ext);
        if ($signed(sum) > $signed(SAT_HI))
        begin
            sat_height = SAT_HI[C-1:0];
        end
        else if ($signed(sum) < $signed(SAT_LO))
        begin
            sat_height = SAT_LO[C-1:0];
        end
        else
        begin
            sat_height = sum[C-1:0];
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (is_query)
                begin
                    state_next = (n_eff < CNT_BITS'(2)) ? S_EVAL : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == n_eff - 1'b1) state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = div_start ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_stat.done) state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                point_count_reg <= cfg_write_data;
            end
            if (is_query)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (seg_hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan payload: query x, previous vertex, last matching segment
    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            qx_reg <= x_value;
        end
        if (state_reg == S_SCAN)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            if (seg_hit)
            begin
                vert_hit_reg <= (prev_x_reg == rd_x);
                seg_y3_reg   <= prev_y_reg;
                seg_a_reg    <= diff_a[C-1:0];
                seg_d_reg    <= diff_d[C-1:0];
                seg_dy_reg   <= diff_dy;
            end
        end
    end

    // Result staging
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EVAL && !div_start)
        begin
            res_on_rail_reg <= found_reg;
            res_vert_reg    <= found_reg && vert_hit_reg;
            res_height_reg  <= found_reg ? seg_y3_reg : '0;
        end
        else if (state_reg == S_DIV && div_stat.done)
        begin
            res_on_rail_reg <= 1'b1;
            res_vert_reg    <= 1'b0;
            res_height_reg  <= sat_height;
        end
        if (out_load)
        begin
            on_rail_reg <= res_on_rail_reg;
            vert_reg    <= res_vert_reg;
            height_reg  <= res_height_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign on_rail          = on_rail_reg;
    assign height           = height_reg;
    assign vertical_segment = vert_reg;

    // Checks
    `PHLU_ASSERT_NEXT(a_write_single_cycle, clk, rst_n, accept && !is_query, state_reg == S_IDLE)
    `PHLU_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_reg == S_SCAN, idx_reg < n_eff)
    `PHLU_ASSERT_IMP(a_div_tracked, clk, rst_n, state_reg == S_DIV, div_stat.busy || div_stat.done)
    `PHLU_ASSERT_IMP(a_vert_needs_rail, clk, rst_n, out_valid, on_rail || !vertical_segment)
    `PHLU_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !on_rail, height == '0)

endmodule

// ----- sim/phlu_height_checker.sv -----
// Checker for the polyline height lookup: keeps its own vertex table and point count,
// predicts each query result and compares it with the output channel. Uses phlu_pkg.
module phlu_height_checker #(
    parameter int COORD_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [phlu_pkg::COUNT_BITS-1:0]   cfg_write_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              opcode,
    input  logic [phlu_pkg::INDEX_BITS-1:0]   point_index,
    input  logic signed [COORD_BITS-1:0]      x_value,
    input  logic signed [COORD_BITS-1:0]      y_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              on_rail,
    input  logic signed [COORD_BITS-1:0]      height,
    input  logic                              vertical_segment,
    output int                                mismatch_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import phlu_pkg::*;

    localparam int     TABLE_DEPTH = 1 << INDEX_BITS;
    localparam longint HEIGHT_MAX  = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint HEIGHT_MIN  = -HEIGHT_MAX - 1;

    typedef struct packed {
        logic                         on_rail;
        logic signed [COORD_BITS-1:0] height;
        logic                         vertical;
    } height_result_t;

    logic signed [COORD_BITS-1:0] vertex_x [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0] vertex_y [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]        point_count;
    height_result_t               expected_heights [$];

    initial begin
        mismatch_count = 0;
        pending        = 0;
        point_count    = '0;
    end

    // Height at qx: the last segment that spans qx decides
    function automatic height_result_t predict_height(logic signed [COORD_BITS-1:0] qx);
        height_result_t res;
        int     active;
        longint q, x3, y3, x4, y4, dy, mag, quo, h;
        res    = '0;
        h      = 0;
        q      = longint'(qx);
        active = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(point_count);
        for (int i = 0; i + 1 < active; i++) begin
            x3 = longint'(vertex_x[i]);
            y3 = longint'(vertex_y[i]);
            x4 = longint'(vertex_x[i + 1]);
            y4 = longint'(vertex_y[i + 1]);
            if (q >= x3 && q <= x4) begin
                res.on_rail = 1'b1;
                if (x3 == x4) begin
                    res.vertical = 1'b1;
                    h = y3;
                end else begin
                    // magnitude divide, truncating toward zero
                    dy  = y4 - y3;
                    mag = (dy < 0) ? -dy : dy;
                    quo = ((q - x3) * mag) / (x4 - x3);
                    h   = (dy < 0) ? y3 - quo : y3 + quo;
                    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
                    if (h < HEIGHT_MIN) h = HEIGHT_MIN;
                    res.vertical = 1'b0;
                end
            end
        end
        res.height = res.on_rail ? h[COORD_BITS-1:0] : '0;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Result side first: a result leaving now never belongs to a query entering now
    always @(posedge clk) begin
        height_result_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_heights.size() == 0) begin
                    report_mismatch("result with no query outstanding", longint'(height), 0);
                end else begin
                    want = expected_heights.pop_front();
                    if (on_rail !== want.on_rail)
                        report_mismatch("on_rail", longint'(on_rail), longint'(want.on_rail));
                    if (height !== want.height)
                        report_mismatch("height", longint'(height), longint'(want.height));
                    if (vertical_segment !== want.vertical)
                        report_mismatch("vertical_segment", longint'(vertical_segment),
                                        longint'(want.vertical));
                end
            end
            if (in_valid && !in_stall) begin
                if (opcode == OP_WRITE) begin
                    vertex_x[point_index] = x_value;
                    vertex_y[point_index] = y_value;
                end else begin
                    expected_heights = {expected_heights, predict_height(x_value)};
                end
            end
            if (cfg_write_en)
                point_count = cfg_write_data;
            pending = expected_heights.size();
        end
    end

endmodule

// ----- sim/polyline_height_lookup_unit_tb.sv -----
// Testbench top for polyline_height_lookup_unit: clock, reset, stimulus, stall patterns,
// watchdog and verdict. Depends on phlu_pkg, the DUT and phlu_height_checker.
module polyline_height_lookup_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import phlu_pkg::*;

    localparam int COORD_BITS      = 24;
    localparam int TABLE_DEPTH     = 1 << INDEX_BITS;
    localparam int X_MAX           = 8388607;
    localparam int X_MIN           = -8388608;
    localparam int SETTLE_CYCLES   = 200;
    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASE_ITEMS     = 100;

    logic                          clk              = 1'b0;
    logic                          rst_n            = 1'b0;
    logic                          cfg_write_en     = 1'b0;
    logic [COUNT_BITS-1:0]         cfg_write_data   = '0;
    logic                          in_valid         = 1'b0;
    logic                          in_stall;
    logic                          opcode           = OP_WRITE;
    logic [INDEX_BITS-1:0]         point_index      = '0;
    logic signed [COORD_BITS-1:0]  x_value          = '0;
    logic signed [COORD_BITS-1:0]  y_value          = '0;
    logic                          out_valid;
    logic                          out_stall        = 1'b0;
    logic                          on_rail;
    logic signed [COORD_BITS-1:0]  height;
    logic                          vertical_segment;

    int  mismatch_count;
    int  pending;
    bit  hold_request = 1'b0;
    int  burst_left   = 0;
    int  sent_x [TABLE_DEPTH];   // vertex x as last sent, to aim queries

    int unsigned phase_counts [12] = '{2, 64, 3, 127, 8, 17, 0, 40, 100, 5, 1, 64};

    always #5 clk = ~clk;

    polyline_height_lookup_unit #(
        .MAX_POINTS (TABLE_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .point_index      (point_index),
        .x_value          (x_value),
        .y_value          (y_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .on_rail          (on_rail),
        .height           (height),
        .vertical_segment (vertical_segment)
    );

    phlu_height_checker #(
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .point_index      (point_index),
        .x_value          (x_value),
        .y_value          (y_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .on_rail          (on_rail),
        .height           (height),
        .vertical_segment (vertical_segment),
        .mismatch_count   (mismatch_count),
        .pending          (pending)
    );

    // Offer one transaction, called and returning at a falling edge; bursts with gaps
    task automatic send_item(logic op, int idx, int x, int y);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        opcode      <= op;
        point_index <= idx[INDEX_BITS-1:0];
        x_value     <= x[COORD_BITS-1:0];
        y_value     <= y[COORD_BITS-1:0];
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (op == OP_WRITE)
            sent_x[idx[INDEX_BITS-1:0]] = int'($signed(x[COORD_BITS-1:0]));
    endtask

    // Point count changes only once the block has drained
    task automatic set_count(int unsigned n);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_data <= n[COUNT_BITS-1:0];
        cfg_write_en   <= 1'b1;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Lay down a left-to-right polyline over the active slots, then mostly query it;
    // with hold set, the receiver holds off while the queries keep coming
    task automatic run_phase(int unsigned new_count, int unsigned items, bit hold);
        int unsigned pts, sent, span, pick;
        int xcur, step, lo, hi, qx;
        set_count(new_count);
        pts = (new_count > TABLE_DEPTH) ? TABLE_DEPTH : new_count;
        case ($urandom_range(0, 2))
            0:       span = 16;
            1:       span = 4096;
            default: span = (pts > 1) ? (32'd1 << 24) / pts : 32'd1 << 20;
        endcase
        xcur = int'($urandom_range(0, X_MAX)) - X_MAX - 1;
        for (int s = 0; s < int'(pts); s++) begin
            if (s > 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    step = 0;                                   // vertical segment
                else if (pick < 12)
                    step = -int'($urandom_range(1, span));      // reversed segment
                else
                    step = int'($urandom_range(1, span));
                xcur += step;
                if (xcur > X_MAX) xcur = X_MAX;
                if (xcur < X_MIN) xcur = X_MIN;
            end
            send_item(OP_WRITE, s, xcur, int'($urandom));
        end
        if (hold)
            hold_request = 1'b1;
        sent = pts;
        while (sent < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // stray vertex write anywhere in the table
                send_item(OP_WRITE, $urandom_range(0, TABLE_DEPTH - 1), int'($urandom),
                          int'($urandom));
            end else begin
                lo = 0;
                hi = 0;
                if (pts > 0) begin
                    lo = sent_x[0];
                    hi = sent_x[0];
                    for (int s = 1; s < int'(pts); s++) begin
                        if (sent_x[s] < lo) lo = sent_x[s];
                        if (sent_x[s] > hi) hi = sent_x[s];
                    end
                end
                if (pick < 65)
                    qx = lo + int'($urandom_range(0, hi - lo));
                else if (pick < 85 && pts > 0)
                    qx = sent_x[$urandom_range(0, pts - 1)] + int'($urandom_range(0, 2)) - 1;
                else
                    qx = int'($urandom);
                send_item(OP_QUERY, $urandom_range(0, TABLE_DEPTH - 1), qx, int'($urandom));
            end
            sent++;
        end
    endtask

    // Receiver stall pattern, with one long hold-off on request
    initial begin
        int stretch, pct;
        @(posedge rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                stretch = $urandom_range(1, 50);
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 25;
                    2:       pct = 60;
                    default: pct = 90;
                endcase
                repeat (stretch) begin
                    @(negedge clk);
                    out_stall <= ($urandom_range(0, 99) < pct);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no points at all
        send_item(OP_QUERY, 0, 0, 0);
        send_item(OP_WRITE, 0, 100, 5);
        send_item(OP_WRITE, 1, 100, -7);
        // a single point gives no segment
        set_count(1);
        send_item(OP_QUERY, 0, 100, 0);
        // vertical segment, and queries just off it
        set_count(2);
        send_item(OP_QUERY, 0, 100, 0);
        send_item(OP_QUERY, 0, 99, 0);
        send_item(OP_QUERY, TABLE_DEPTH - 1, 101, -1);
        // full-range coordinates, a shared vertex and a reversed segment
        send_item(OP_WRITE, 0, X_MIN, X_MAX);
        send_item(OP_WRITE, 1, -256, X_MIN);
        send_item(OP_WRITE, 2, X_MAX, X_MAX);
        send_item(OP_WRITE, 3, 100, 0);
        set_count(4);
        send_item(OP_QUERY, 0, X_MIN, 0);
        send_item(OP_QUERY, 0, -257, 0);
        send_item(OP_QUERY, 0, -256, 0);
        send_item(OP_QUERY, 0, X_MAX, X_MAX);
        send_item(OP_QUERY, 0, 0, 0);
        send_item(OP_QUERY, 0, 100, X_MIN);
        send_item(OP_QUERY, TABLE_DEPTH - 1, 8388000, 0);

        for (int p = 0; p < 12; p++) begin
            run_phase(phase_counts[p], PHASE_ITEMS, p == 2);
        end

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
